### src/speed_adaptive_phase_oscillator_unit_macros.svh
// assertion macros shared by the checker
`ifndef SPEED_ADAPTIVE_PHASE_OSCILLATOR_UNIT_MACROS_SVH
`define SPEED_ADAPTIVE_PHASE_OSCILLATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SAPO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SAPO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/sapo_pkg.sv
// ----------------------------------------------------------------------------
// sapo_pkg
// Shared constants, register indexes and the cordic arctangent table.
// ----------------------------------------------------------------------------
package sapo_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int CORDIC_STAGES   = 24;
  localparam int CORDIC_W        = 34;
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN_INV = CORDIC_W'(652032874);

  // serial multiplier operand widths
  localparam int MUL_A_W = PHASE_BITS;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // restoring divider dividend width
  localparam int DVD_W = (PHASE_BITS + 12 > 32) ? PHASE_BITS + 12 : 32;

  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ADAPTIVE_MODE,
    REG_SLOW_PERIOD,
    REG_FAST_PERIOD,
    REG_FULL_SPEED,
    REG_DECAY_GAIN,
    REG_REST_SPEED,
    REG_FIXED_PERIOD,
    REG_STEP_TIME
  } reg_idx_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### src/sapo_mult.sv
// ----------------------------------------------------------------------------
// sapo_mult
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sapo_mult (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sapo_pkg::MUL_A_W-1:0]     a,
  input  logic [sapo_pkg::MUL_B_W-1:0]     b,
  output logic                             done,
  output logic [sapo_pkg::PROD_W-1:0]      prod
);

  localparam int CNT_W = $clog2(sapo_pkg::MUL_B_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [sapo_pkg::MUL_A_W-1:0]  av;
  logic [sapo_pkg::PROD_W-1:0]   p;
  logic [sapo_pkg::MUL_A_W:0]    sum;

  assign sum  = {1'b0, p[sapo_pkg::PROD_W-1:sapo_pkg::MUL_B_W]} +
                (p[0] ? {1'b0, av} : '0);
  assign prod = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        p    <= {{sapo_pkg::MUL_A_W{1'b0}}, b};
        av   <= a;
        cnt  <= CNT_W'(sapo_pkg::MUL_B_W);
        busy <= 1'b1;
      end else if (busy) begin
        p   <= {sum, p[sapo_pkg::MUL_B_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/sapo_div.sv
// ----------------------------------------------------------------------------
// sapo_div
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module sapo_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sapo_pkg::DVD_W-1:0]      dividend,
  input  logic [15:0]                     divisor,
  output logic                            done,
  output logic [sapo_pkg::PHASE_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(sapo_pkg::DVD_W + 1);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [sapo_pkg::DVD_W-1:0]   dvd;
  logic [15:0]                  dvs;
  logic [15:0]                  rem;
  logic [16:0]                  trial;
  logic [16:0]                  diff;
  logic                         ge;

  assign trial = {rem, dvd[sapo_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= CNT_W'(sapo_pkg::DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // remainder stays below the divisor, so 16 bits hold it
        rem <= ge ? diff[15:0] : trial[15:0];
        quo <= {quo[sapo_pkg::PHASE_BITS-2:0], ge};
        dvd <= {dvd[sapo_pkg::DVD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/sapo_isqrt.sv
// ----------------------------------------------------------------------------
// sapo_isqrt
// Integer square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sapo_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] v;
  logic [31:0] res;
  logic [31:0] one;
  logic [31:0] trial;
  logic        ge;

  assign trial = res + one;
  assign ge    = v >= trial;
  assign root  = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 5'd1);
      if (start) begin
        v    <= radicand;
        res  <= '0;
        one  <= 32'h40000000;
        cnt  <= 5'd16;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          v   <= v - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/sapo_cordic.sv
// ----------------------------------------------------------------------------
// sapo_cordic
// Iterative rotation-mode cordic, one stage per cycle, Q1.15 outputs.
// ----------------------------------------------------------------------------
module sapo_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [sapo_pkg::SINE_TABLE_BITS-1:0] pos,
  output logic                                 done,
  output logic signed [15:0]                   sine,
  output logic signed [15:0]                   cosine
);

  localparam int W = sapo_pkg::CORDIC_W;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t               state;
  logic [4:0]            iter;
  logic                  flip;
  logic signed [W-1:0]   x;
  logic signed [W-1:0]   y;
  logic signed [W-1:0]   z;
  logic signed [W-1:0]   dx;
  logic signed [W-1:0]   dy;
  logic signed [W-1:0]   at;
  logic [31:0]           ang;
  logic                  ang_flip;
  logic [31:0]           ang_f;
  logic signed [W-1:0]   xo;
  logic signed [W-1:0]   yo;

  function automatic logic signed [15:0] to_q15(input logic signed [W-1:0] v);
    logic signed [W:0]   r;
    logic signed [W-15:0] q;
    r = {v[W-1], v} + (W+1)'(16384);
    q = r[W:15];
    if (q > (W-14)'(32767)) begin
      return 16'sh7FFF;
    end else if (q < -(W-14)'(32768)) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  assign ang      = {pos, {(32-sapo_pkg::SINE_TABLE_BITS){1'b0}}};
  // angle in the left half turn is folded by a half turn
  assign ang_flip = ang[31] ^ ang[30];
  assign ang_f    = {ang[31] ^ ang_flip, ang[30:0]};
  assign dx       = y >>> iter;
  assign dy       = x >>> iter;
  assign at       = W'(sapo_pkg::atan_turn(iter));
  assign xo       = flip ? -x : x;
  assign yo       = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      iter  <= '0;
    end else begin
      done <= (state == C_FIN);
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x     <= sapo_pkg::CORDIC_GAIN_INV;
            y     <= '0;
            z     <= W'(signed'(ang_f));
            flip  <= ang_flip;
            iter  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z[W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          iter <= iter + 1'b1;
          if (iter == 5'(sapo_pkg::CORDIC_STAGES - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          sine   <= to_q15(yo);
          cosine <= to_q15(xo);
          state  <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### src/speed_adaptive_phase_oscillator_unit.sv
// ----------------------------------------------------------------------------
// speed_adaptive_phase_oscillator_unit
// Phase oscillator whose period follows the commanded planar speed.
// ----------------------------------------------------------------------------
// One velocity transfer in, one sine/cosine transfer out. The block takes one
// item at a time; in_stall stays high from acceptance until the result is
// loaded into the output register, and a finished result may wait there while
// the next item is accepted. All arithmetic runs bit-serially through one
// shared shift-add multiplier, one restoring divider, an integer square root
// and a 24-stage cordic. When moving below the speed threshold, the speed
// ratio needs its own division.
module speed_adaptive_phase_oscillator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sapo_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              vel_x,
  input  logic signed [15:0]              vel_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              sine_out,
  output logic signed [15:0]              cosine_out
);

  localparam int PB = sapo_pkg::PHASE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_ALPHA, S_MW, S_MR, S_INC, S_DECAY, S_SINE, S_OUT
  } state_t;

  // configuration
  logic        adaptive_mode;
  logic [15:0] slow_period;
  logic [15:0] fast_period;
  logic [15:0] full_speed;
  logic [15:0] decay_gain;
  logic [15:0] rest_speed;
  logic [15:0] fixed_period;
  logic [15:0] step_time;

  sapo_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = sapo_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode <= 1'b1;
      slow_period   <= 16'd4096;
      fast_period   <= 16'd2867;
      full_speed    <= 16'd3277;
      decay_gain    <= 16'd62259;
      rest_speed    <= 16'd410;
      fixed_period  <= 16'd4096;
      step_time     <= 16'd1311;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sapo_pkg::REG_ADAPTIVE_MODE: adaptive_mode <= pwdata[0];
        sapo_pkg::REG_SLOW_PERIOD:   slow_period   <= pwdata[15:0];
        sapo_pkg::REG_FAST_PERIOD:   fast_period   <= pwdata[15:0];
        sapo_pkg::REG_FULL_SPEED:    full_speed    <= pwdata[15:0];
        sapo_pkg::REG_DECAY_GAIN:    decay_gain    <= pwdata[15:0];
        sapo_pkg::REG_REST_SPEED:    rest_speed    <= pwdata[15:0];
        sapo_pkg::REG_FIXED_PERIOD:  fixed_period  <= pwdata[15:0];
        sapo_pkg::REG_STEP_TIME:     step_time     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sapo_pkg::REG_ADAPTIVE_MODE: prdata = {31'd0, adaptive_mode};
      sapo_pkg::REG_SLOW_PERIOD:   prdata = {16'd0, slow_period};
      sapo_pkg::REG_FAST_PERIOD:   prdata = {16'd0, fast_period};
      sapo_pkg::REG_FULL_SPEED:    prdata = {16'd0, full_speed};
      sapo_pkg::REG_DECAY_GAIN:    prdata = {16'd0, decay_gain};
      sapo_pkg::REG_REST_SPEED:    prdata = {16'd0, rest_speed};
      sapo_pkg::REG_FIXED_PERIOD:  prdata = {16'd0, fixed_period};
      sapo_pkg::REG_STEP_TIME:     prdata = {16'd0, step_time};
      default:                     prdata = '0;
    endcase
  end

  // arithmetic units
  logic                          mul_start, mul_done;
  logic [sapo_pkg::MUL_A_W-1:0]  mul_a;
  logic [sapo_pkg::MUL_B_W-1:0]  mul_b;
  logic [sapo_pkg::PROD_W-1:0]   mul_prod;
  logic                          div_start, div_done;
  logic [sapo_pkg::DVD_W-1:0]    div_dvd;
  logic [15:0]                   div_dvs;
  logic [PB-1:0]                 div_quo;
  logic                          sq_start, sq_done;
  logic [15:0]                   sq_root;
  logic                          cor_start, cor_done;
  logic signed [15:0]            cor_sine, cor_cosine;

  sapo_mult u_mult (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  sapo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quo(div_quo)
  );

  // datapath registers
  state_t        state;
  logic [15:0]   ay;
  logic [31:0]   sqsum;
  logic [16:0]   alpha;
  logic [32:0]   psum;
  logic [PB-1:0] phase_acc;
  logic [32:0]   per_sum;
  logic [15:0]   period;
  logic [sapo_pkg::DVD_W-1:0] inc_dvd;
  logic [15:0]   abs_x;
  logic [15:0]   abs_y;
  logic          mul_go, div_go, sq_go, cor_go;
  logic          out_load;

  sapo_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sqsum),
    .done(sq_done), .root(sq_root)
  );

  sapo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start),
    .pos(phase_acc[PB-1 -: sapo_pkg::SINE_TABLE_BITS]),
    .done(cor_done), .sine(cor_sine), .cosine(cor_cosine)
  );

  assign in_stall = (state != S_IDLE);
  assign per_sum  = psum + mul_prod[32:0];
  assign period   = per_sum[31:16];
  assign inc_dvd  = sapo_pkg::DVD_W'({step_time, {(PB-4){1'b0}}});
  // magnitudes as unsigned, so -32768 becomes 32768
  assign abs_x    = vel_x[15] ? 16'(-vel_x) : 16'(vel_x);
  assign abs_y    = vel_y[15] ? 16'(-vel_y) : 16'(vel_y);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // unit start requests, registered below
  always_comb begin
    mul_go = 1'b0;
    div_go = 1'b0;
    sq_go  = 1'b0;
    cor_go = 1'b0;
    unique case (state)
      S_IDLE: begin
        mul_go = in_valid && adaptive_mode;
        div_go = in_valid && !adaptive_mode;
      end
      S_SQX:   mul_go = mul_done;
      S_SQY:   sq_go  = mul_done;
      S_SQRT: begin
        mul_go = sq_done && ((sq_root < rest_speed) || (sq_root >= full_speed));
        div_go = sq_done && (sq_root >= rest_speed) && (sq_root < full_speed);
      end
      S_ALPHA: mul_go = div_done;
      S_MW:    mul_go = mul_done;
      S_MR:    div_go = mul_done;
      S_INC:   cor_go = div_done;
      S_DECAY: cor_go = mul_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      phase_acc <= '0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      cor_start <= 1'b0;
    end else begin
      mul_start <= mul_go;
      div_start <= div_go;
      sq_start  <= sq_go;
      cor_start <= cor_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ay <= abs_y;
            if (adaptive_mode) begin
              mul_a <= PB'(abs_x);
              mul_b <= {1'b0, abs_x};
              state <= S_SQX;
            end else begin
              div_dvd <= inc_dvd;
              div_dvs <= (fixed_period == 16'd0) ? 16'd1 : fixed_period;
              state   <= S_INC;
            end
          end
        end
        S_SQX: begin
          if (mul_done) begin
            sqsum <= mul_prod[31:0];
            mul_a <= PB'(ay);
            mul_b <= {1'b0, ay};
            state <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            sqsum <= sqsum + mul_prod[31:0];
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            priority if (sq_root < rest_speed) begin
              mul_a <= phase_acc;
              mul_b <= {1'b0, decay_gain};
              state <= S_DECAY;
            end else if (sq_root >= full_speed) begin
              alpha <= 17'h10000;
              mul_a <= PB'(slow_period);
              mul_b <= '0;
              state <= S_MW;
            end else begin
              div_dvd <= sapo_pkg::DVD_W'({sq_root, 16'd0});
              div_dvs <= full_speed;
              state   <= S_ALPHA;
            end
          end
        end
        S_ALPHA: begin
          if (div_done) begin
            alpha <= {1'b0, div_quo[15:0]};
            mul_a <= PB'(slow_period);
            mul_b <= 17'h10000 - {1'b0, div_quo[15:0]};
            state <= S_MW;
          end
        end
        S_MW: begin
          if (mul_done) begin
            psum  <= mul_prod[32:0];
            mul_a <= PB'(fast_period);
            mul_b <= alpha;
            state <= S_MR;
          end
        end
        S_MR: begin
          if (mul_done) begin
            div_dvd <= inc_dvd;
            div_dvs <= (period == 16'd0) ? 16'd1 : period;
            state   <= S_INC;
          end
        end
        S_INC: begin
          if (div_done) begin
            phase_acc <= phase_acc + div_quo;
            state     <= S_SINE;
          end
        end
        S_DECAY: begin
          if (mul_done) begin
            phase_acc <= mul_prod[PB+15:16];
            state     <= S_SINE;
          end
        end
        S_SINE: begin
          if (cor_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            sine_out   <= cor_sine;
            cosine_out <= cor_cosine;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/sapo_checker.sv
// ----------------------------------------------------------------------------
// sapo_checker
// Port-level checks on the oscillator's transfer behavior.
// ----------------------------------------------------------------------------
`include "speed_adaptive_phase_oscillator_unit_macros.svh"

module sapo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] sine_out,
  input logic signed [15:0] cosine_out
);

  // an accepted item keeps the input side busy
  `SAPO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after transfer")
  // a result only appears while an item is in flight
  `SAPO_ASSERT_NOW(a_rise_from_busy, $rose(out_valid), $past(in_stall), "result without item in flight")
  `SAPO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `SAPO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(sine_out) && $stable(cosine_out), "stalled result changed")

endmodule

bind speed_adaptive_phase_oscillator_unit sapo_checker u_sapo_checker (.*);

### tb/speed_adaptive_phase_oscillator_unit_tb.sv
// ----------------------------------------------------------------------------
// speed_adaptive_phase_oscillator_unit_tb
// Self-checking bench for the speed-adaptive phase oscillator.
// ----------------------------------------------------------------------------
// Velocity transfers come from a queue, with bursts and gaps on the sender
// side and a stall pattern on the result side. A local model keeps its own
// phase and register copies and predicts sine and cosine for every accepted
// transfer. Registers are written over the APB port only while the block is
// idle, going through several settings that include the extremes.
module speed_adaptive_phase_oscillator_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } vel_t;

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [sapo_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] vel_x = '0, vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sine_out, cosine_out;

  speed_adaptive_phase_oscillator_unit dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // model state and register copies
  logic        m_adaptive;
  logic [15:0] m_walk, m_run, m_thresh, m_decay, m_still, m_fixed, m_step;
  logic [sapo_pkg::PHASE_BITS-1:0] m_phase;

  vel_t  vel_queue[$];
  trig_t trig_expected[$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  bit    feeding = 1'b0;
  bit    hold_off = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] round_q15(longint v);
    longint r;
    r = floor_shr(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic [31:0] atan_lut(int i);
    logic [31:0] t[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
      32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
      32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
      32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic trig_t phase_to_trig(logic [sapo_pkg::PHASE_BITS-1:0] ph);
    logic [31:0] ang;
    bit flip;
    longint x, y, z, dx, dy;
    trig_t t;
    ang = {ph[sapo_pkg::PHASE_BITS-1 -: sapo_pkg::SINE_TABLE_BITS],
           {(32-sapo_pkg::SINE_TABLE_BITS){1'b0}}};
    flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
    if (flip) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    t.sin_v = round_q15(y);
    t.cos_v = round_q15(x);
    return t;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void advance_phase(longint period);
    longint inc;
    if (period == 0) period = 1;
    inc = (longint'(m_step) << (sapo_pkg::PHASE_BITS - 4)) / period;
    m_phase = sapo_pkg::PHASE_BITS'(longint'(m_phase) + inc);
  endfunction

  function automatic trig_t predict_oscillator(vel_t v);
    longint vx, vy, speed, alpha, period;
    vx = v.vx;
    vy = v.vy;
    if (m_adaptive) begin
      speed = int_sqrt(vx * vx + vy * vy);
      if (speed < m_still) begin
        m_phase = sapo_pkg::PHASE_BITS'((longint'(m_phase) * m_decay) >> 16);
      end else begin
        if (speed >= m_thresh) alpha = 65536;
        else alpha = (speed << 16) / m_thresh;
        period = (longint'(m_walk) * (65536 - alpha) + longint'(m_run) * alpha) >> 16;
        advance_phase(period);
      end
    end else begin
      advance_phase(m_fixed);
    end
    return phase_to_trig(m_phase);
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin : drive_proc
    bit   accepted;
    bit   go;
    vel_t cur;
    accepted = in_valid && !in_stall;
    if (accepted) begin
      cur = vel_queue.pop_front();
      trig_expected = {trig_expected, predict_oscillator(cur)};
    end
    if (!in_valid || accepted) begin
      if (accepted && burst_left <= 1) begin
        // burst over, start a gap
        in_valid   <= 1'b0;
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        burst_left <= $urandom_range(1, 12);
      end else begin
        go = feeding && !hold_off && vel_queue.size() > 0 && (gap_left == 0);
        in_valid <= go;
        if (go) begin
          vel_x <= vel_queue[0].vx;
          vel_y <= vel_queue[0].vy;
        end
        if (accepted) burst_left <= burst_left - 1;
        else if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // monitor and result-side stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (trig_expected.size() == 0) begin
        $error("unexpected transfer sin=%0d cos=%0d", sine_out, cosine_out);
        fail_count++;
      end else begin
        trig_t e;
        e = trig_expected.pop_front();
        if (sine_out !== e.sin_v) begin
          $error("sine_out expected %0d actual %0d", e.sin_v, sine_out);
          fail_count++;
        end
        if (cosine_out !== e.cos_v) begin
          $error("cosine_out expected %0d actual %0d", e.cos_v, cosine_out);
          fail_count++;
        end
      end
    end
    if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // watchdog on accepted transfers
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apb_write(sapo_pkg::reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sapo_pkg::CFG_ADDR_W'(4 * int'(idx)); pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      sapo_pkg::REG_ADAPTIVE_MODE: m_adaptive = val[0];
      sapo_pkg::REG_SLOW_PERIOD:   m_walk = val;
      sapo_pkg::REG_FAST_PERIOD:   m_run = val;
      sapo_pkg::REG_FULL_SPEED:    m_thresh = val;
      sapo_pkg::REG_DECAY_GAIN:    m_decay = val;
      sapo_pkg::REG_REST_SPEED:    m_still = val;
      sapo_pkg::REG_FIXED_PERIOD:  m_fixed = val;
      sapo_pkg::REG_STEP_TIME:     m_step = val;
      default: ;
    endcase
  endtask

  task automatic add_item(vel_t v);
    vel_queue = {vel_queue, v};
  endtask

  // run queued items and wait until the block is idle again
  task automatic drain;
    feeding = 1'b1;
    while (vel_queue.size() > 0 || in_valid) @(posedge clk);
    feeding = 1'b0;
    while (trig_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic vel_t rand_vel(int mag);
    vel_t v;
    int lim;
    lim = mag;
    v.vx = 16'($signed($urandom_range(0, 2 * lim)) - lim);
    v.vy = 16'($signed($urandom_range(0, 2 * lim)) - lim);
    if ($urandom_range(0, 15) == 0) v = vel_t'($urandom);
    return v;
  endfunction

  task automatic queue_random(int n);
    int mags[4] = '{400, 3300, 8000, 32767};
    for (int i = 0; i < n; i++) add_item(rand_vel(mags[$urandom_range(0, 3)]));
  endtask

  task automatic random_settings;
    apb_write(sapo_pkg::REG_ADAPTIVE_MODE, 16'($urandom_range(0, 3) != 0));
    apb_write(sapo_pkg::REG_SLOW_PERIOD, 16'($urandom_range(1, 65535)));
    apb_write(sapo_pkg::REG_FAST_PERIOD, 16'($urandom_range(1, 65535)));
    apb_write(sapo_pkg::REG_FULL_SPEED, 16'($urandom_range(1, 65535)));
    apb_write(sapo_pkg::REG_DECAY_GAIN, 16'($urandom));
    apb_write(sapo_pkg::REG_REST_SPEED, 16'($urandom_range(0, 2000)));
    apb_write(sapo_pkg::REG_FIXED_PERIOD, 16'($urandom_range(1, 65535)));
    apb_write(sapo_pkg::REG_STEP_TIME, 16'($urandom_range(1, 65535)));
  endtask

  initial begin
    m_adaptive = 1'b1; m_walk = 4096; m_run = 2867; m_thresh = 3277;
    m_decay = 62259; m_still = 410; m_fixed = 4096; m_step = 1311;
    m_phase = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under reset settings
    add_item(vel_t'{16'sh7FFF, 16'sh7FFF});
    add_item(vel_t'{-16'sh8000, -16'sh8000});
    add_item(vel_t'{16'sh0000, 16'sh0000});
    add_item(vel_t'{16'sh1000, 16'sh0000});
    add_item(vel_t'{16'sh0000, 16'sh0400});
    add_item(vel_t'{16'sh0CCD, -16'sh0001});
    add_item(vel_t'{16'sh0000, 16'sh0000});
    add_item(vel_t'{16'sh5555, -16'sh2AAB});
    drain();

    // zero speed threshold, zero-period handling, large increments
    apb_write(sapo_pkg::REG_FULL_SPEED, 16'd0);
    apb_write(sapo_pkg::REG_FAST_PERIOD, 16'd0);
    apb_write(sapo_pkg::REG_STEP_TIME, 16'hFFFF);
    apb_write(sapo_pkg::REG_REST_SPEED, 16'd0);
    for (int i = 0; i < 4; i++) add_item(rand_vel(32767));
    drain();

    // fixed mode, extreme periods; decay gain and slow period set but unused here
    apb_write(sapo_pkg::REG_ADAPTIVE_MODE, 16'd0);
    apb_write(sapo_pkg::REG_FIXED_PERIOD, 16'd1);
    apb_write(sapo_pkg::REG_DECAY_GAIN, 16'hFFFF);
    apb_write(sapo_pkg::REG_SLOW_PERIOD, 16'hFFFF);
    for (int i = 0; i < 3; i++) add_item(rand_vel(100));
    drain();
    apb_write(sapo_pkg::REG_FIXED_PERIOD, 16'hFFFF);
    apb_write(sapo_pkg::REG_STEP_TIME, 16'd1);
    for (int i = 0; i < 2; i++) add_item(rand_vel(100));
    drain();
    // quarter-turn phase steps in fixed mode
    apb_write(sapo_pkg::REG_FIXED_PERIOD, 16'd4096);
    apb_write(sapo_pkg::REG_STEP_TIME, 16'h4000);
    for (int i = 0; i < 5; i++) add_item(rand_vel(100));
    drain();

    // back to adaptive, standstill all the time with zero decay
    apb_write(sapo_pkg::REG_ADAPTIVE_MODE, 16'd1);
    apb_write(sapo_pkg::REG_REST_SPEED, 16'hFFFF);
    apb_write(sapo_pkg::REG_DECAY_GAIN, 16'd0);
    for (int i = 0; i < 3; i++) add_item(rand_vel(32767));
    drain();

    // random phases, settings changed between them
    for (int p = 0; p < 12; p++) begin
      random_settings();
      queue_random(50);
      if (p == 6) begin
        // sender pauses until everything outstanding has come back
        feeding = 1'b1;
        while (vel_queue.size() > 25) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid) @(posedge clk);
        @(posedge clk);
        while (trig_expected.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
